// ----- rtl/arsl_pkg.sv -----
// arsl_pkg: shared constants, codes, cell control struct and tree sizing helpers
// for the address range lookup block; no dependencies
`default_nettype none

package arsl_pkg;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 32;
    localparam int TAG_W      = 16;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_TAG_BITS    = 16;

    // fan-in of one node of the registered readout tree
    localparam int TREE_RADIX = 16;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
    localparam logic [OP_W-1:0] OP_EXACT   = 2'd2;
    localparam logic [OP_W-1:0] OP_CONTAIN = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd3;

    typedef struct packed {
        logic cmp_en;   // cells compare their base against the query
        logic ins_en;   // cells above the insert point shift up by one
    } cell_ctrl_t;

    // node count of tree level l (level 0 is the leaves)
    function automatic int level_count(int n, int l);
        int c;
        c = n;
        for (int k = 0; k < l; k++)
            c = (c + TREE_RADIX - 1) / TREE_RADIX;
        return c;
    endfunction

    // registered levels needed to reduce n leaves to one node
    function automatic int tree_levels(int n);
        int c;
        int lv;
        c  = n;
        lv = 0;
        while (c > 1)
        begin
            c  = (c + TREE_RADIX - 1) / TREE_RADIX;
            lv = lv + 1;
        end
        return lv;
    endfunction

    // position of the first node of level l in the flat node array
    function automatic int level_offset(int n, int l);
        int s;
        s = 0;
        for (int k = 1; k < l; k++)
            s = s + level_count(n, k);
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/arsl_req_if.sv -----
// arsl_req_if: request channel (operation and region fields) with valid/ready
// depends on arsl_pkg for field widths
`default_nettype none

interface arsl_req_if;
    logic                        valid;
    logic                        ready;
    logic [arsl_pkg::OP_W-1:0]   op;
    logic [arsl_pkg::ADDR_W-1:0] address;
    logic [arsl_pkg::SIZE_W-1:0] region_size;
    logic [arsl_pkg::TAG_W-1:0]  tag;

    modport source (output valid, op, address, region_size, tag, input ready);
    modport sink   (input valid, op, address, region_size, tag, output ready);
endinterface

`default_nettype wire

// ----- rtl/arsl_rsp_if.sv -----
// arsl_rsp_if: result channel (status and reported entry) with valid/ready
// depends on arsl_pkg for field widths
`default_nettype none

interface arsl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [arsl_pkg::STATUS_W-1:0] status;
    logic [arsl_pkg::TAG_W-1:0]    entry_tag;
    logic [arsl_pkg::ADDR_W-1:0]   entry_base;
    logic [arsl_pkg::SIZE_W-1:0]   entry_size;
    logic                          entry_valid;

    modport source (output valid, status, entry_tag, entry_base, entry_size, entry_valid,
                    input ready);
    modport sink   (input valid, status, entry_tag, entry_base, entry_size, entry_valid,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/arsl_cell.sv -----
// arsl_cell: one slot of the sorted region chain; compares, shifts on insert,
// and drives its entry into the readout tree when it is the floor; uses arsl_pkg
`default_nettype none

module arsl_cell #(
    parameter int TABLE_DEPTH = arsl_pkg::DEFAULT_TABLE_DEPTH,
    parameter int TAG_BITS    = arsl_pkg::DEFAULT_TAG_BITS,
    parameter int IDX         = 0
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire arsl_pkg::cell_ctrl_t                ctrl,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    count,
    input  wire logic [arsl_pkg::ADDR_W-1:0]         query_base,
    input  wire logic [arsl_pkg::SIZE_W-1:0]         new_size,
    input  wire logic [TAG_BITS-1:0]                 new_tag,
    input  wire logic                                prev_le,
    input  wire logic [arsl_pkg::ADDR_W-1:0]         prev_base,
    input  wire logic [arsl_pkg::SIZE_W-1:0]         prev_size,
    input  wire logic [TAG_BITS-1:0]                 prev_tag,
    input  wire logic                                next_le,
    output logic                                     le,
    output logic                                     floor_hit,
    output logic [arsl_pkg::ADDR_W-1:0]              base,
    output logic [arsl_pkg::SIZE_W-1:0]              size,
    output logic [TAG_BITS-1:0]                      tag,
    output logic [arsl_pkg::ADDR_W+arsl_pkg::SIZE_W+TAG_BITS:0] leaf
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                        le_reg;
    logic [arsl_pkg::ADDR_W-1:0] base_reg;
    logic [arsl_pkg::SIZE_W-1:0] size_reg;
    logic [TAG_BITS-1:0]         tag_reg;
    logic                        occupied;

    assign occupied = count > CNT_W'(IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            le_reg <= occupied && (base_reg <= query_base);
        end
    end

    // entries above the insert point move up one slot, the slot at the point takes the new one
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && !le_reg)
        begin
            if (prev_le)
            begin
                base_reg <= query_base;
                size_reg <= new_size;
                tag_reg  <= new_tag;
            end
            else
            begin
                base_reg <= prev_base;
                size_reg <= prev_size;
                tag_reg  <= prev_tag;
            end
        end
    end

    assign le        = le_reg;
    assign floor_hit = le_reg && !next_le;
    assign base      = base_reg;
    assign size      = size_reg;
    assign tag       = tag_reg;
    assign leaf      = floor_hit ? {1'b1, base_reg, size_reg, tag_reg} : '0;

endmodule

`default_nettype wire

// ----- rtl/arsl_or_tree.sv -----
// arsl_or_tree: registered OR reduction of one-hot leaves, radix from arsl_pkg,
// one register level per tree level; uses arsl_pkg sizing helpers
`default_nettype none

module arsl_or_tree #(
    parameter int WIDTH  = 81,
    parameter int LEAVES = arsl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic [WIDTH-1:0] leaf [LEAVES],
    output logic [WIDTH-1:0]      root
);

    localparam int RADIX  = arsl_pkg::TREE_RADIX;
    localparam int LEVELS = arsl_pkg::tree_levels(LEAVES);
    localparam int TOTAL  = arsl_pkg::level_offset(LEAVES, LEVELS + 1);

    logic [WIDTH-1:0] node_reg [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++)
    begin : lvl_g
        localparam int PREV_CNT = arsl_pkg::level_count(LEAVES, l - 1);
        localparam int CNT      = arsl_pkg::level_count(LEAVES, l);
        localparam int PREV_OFF = (l > 1) ? arsl_pkg::level_offset(LEAVES, l - 1) : 0;
        localparam int OFF      = arsl_pkg::level_offset(LEAVES, l);

        for (genvar j = 0; j < CNT; j++)
        begin : node_g
            logic [WIDTH-1:0] acc;

            always_comb
            begin
                acc = '0;
                for (int c = 0; c < RADIX; c++)
                begin
                    if (j * RADIX + c < PREV_CNT)
                    begin
                        if (l == 1)
                            acc = acc | leaf[j * RADIX + c];
                        else
                            acc = acc | node_reg[PREV_OFF + j * RADIX + c];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                node_reg[OFF + j] <= acc;
            end
        end
    end

    assign root = node_reg[TOTAL - 1];

endmodule

`default_nettype wire

// ----- rtl/address_range_symbol_lookup.sv -----
// address_range_symbol_lookup: sorted region table built as a chain of cells
// with a registered readout tree; uses arsl_pkg, arsl_req_if, arsl_rsp_if,
// arsl_cell and arsl_or_tree
//
//   channel  dir  fields                                              transfer when
//   req      in   op, address, region_size, tag                       valid && ready
//   rsp      out  status, entry_tag, entry_base, entry_size,          valid && ready
//                 entry_valid
//
// one item at a time: a compare step in all cells, then the registered levels of
// the radix-16 readout tree (tree_levels(TABLE_DEPTH), 2 at 256 entries), then a
// decide step that loads the result register; a new request is taken only once
// the item is through the decide step
// a waiting result does not block the next request; only the decide step holds
// while the result register is still occupied
// reset empties the table at once (entry count to zero); no clearing pass
`default_nettype none

module address_range_symbol_lookup #(
    parameter int TABLE_DEPTH = arsl_pkg::DEFAULT_TABLE_DEPTH,
    parameter int TAG_BITS    = arsl_pkg::DEFAULT_TAG_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    arsl_req_if.sink   req,
    arsl_rsp_if.source rsp
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LEVELS = arsl_pkg::tree_levels(TABLE_DEPTH);
    localparam int WAIT_W = $clog2(LEVELS + 1);
    localparam int ADDR_W = arsl_pkg::ADDR_W;
    localparam int SIZE_W = arsl_pkg::SIZE_W;
    localparam int LEAF_W = ADDR_W + SIZE_W + TAG_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEARCH,
        S_DECIDE
    } state_t;

    // fsm and request capture
    state_t                          state_reg, state_next;
    logic [arsl_pkg::OP_W-1:0]       op_reg, op_next;
    logic [ADDR_W-1:0]               addr_reg, addr_next;
    logic [SIZE_W-1:0]               size_reg, size_next;
    logic [TAG_BITS-1:0]             tag_reg, tag_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [WAIT_W-1:0]               wait_reg, wait_next;

    // result register
    logic                            out_valid_reg, out_valid_next;
    logic [arsl_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [arsl_pkg::TAG_W-1:0]      etag_reg, etag_next;
    logic [ADDR_W-1:0]               ebase_reg, ebase_next;
    logic [SIZE_W-1:0]               esize_reg, esize_next;
    logic                            evalid_reg, evalid_next;

    arsl_pkg::cell_ctrl_t            ctrl;
    logic                            req_fire;
    logic                            out_free;

    // chain wiring
    logic [TABLE_DEPTH-1:0]          le_vec;
    logic [TABLE_DEPTH-1:0]          floor_vec;
    logic [ADDR_W-1:0]               cell_base [TABLE_DEPTH];
    logic [SIZE_W-1:0]               cell_size [TABLE_DEPTH];
    logic [TAG_BITS-1:0]             cell_tag  [TABLE_DEPTH];
    logic [LEAF_W-1:0]               leaf      [TABLE_DEPTH];

    // floor entry coming out of the tree
    logic [LEAF_W-1:0]               root;
    logic                            f_found;
    logic [ADDR_W-1:0]               f_base;
    logic [SIZE_W-1:0]               f_size;
    logic [TAG_BITS-1:0]             f_tag;
    logic                            f_same;
    logic                            f_covers;
    logic [ADDR_W-1:0]               offset;
    logic                            table_full;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_tag   = etag_reg;
    assign rsp.entry_base  = ebase_reg;
    assign rsp.entry_size  = esize_reg;
    assign rsp.entry_valid = evalid_reg;

    // ---- chain of cells ----
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : cell_g
        logic              p_le;
        logic              n_le;
        logic [ADDR_W-1:0] p_base;
        logic [SIZE_W-1:0] p_size;
        logic [TAG_BITS-1:0] p_tag;

        if (i == 0)
        begin : first_g
            // nothing below slot 0, so it always sits at or above the insert point
            assign p_le   = 1'b1;
            assign p_base = '0;
            assign p_size = '0;
            assign p_tag  = '0;
        end
        else
        begin : mid_g
            assign p_le   = le_vec[i-1];
            assign p_base = cell_base[i-1];
            assign p_size = cell_size[i-1];
            assign p_tag  = cell_tag[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : last_g
            assign n_le = 1'b0;
        end
        else
        begin : inner_g
            assign n_le = le_vec[i+1];
        end

        arsl_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .TAG_BITS    (TAG_BITS),
            .IDX         (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .query_base (addr_reg),
            .new_size   (size_reg),
            .new_tag    (tag_reg),
            .prev_le    (p_le),
            .prev_base  (p_base),
            .prev_size  (p_size),
            .prev_tag   (p_tag),
            .next_le    (n_le),
            .le         (le_vec[i]),
            .floor_hit  (floor_vec[i]),
            .base       (cell_base[i]),
            .size       (cell_size[i]),
            .tag        (cell_tag[i]),
            .leaf       (leaf[i])
        );
    end

    // ---- readout of the single floor cell ----
    arsl_or_tree #(
        .WIDTH  (LEAF_W),
        .LEAVES (TABLE_DEPTH)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    assign f_found    = root[LEAF_W-1];
    assign f_base     = root[LEAF_W-2 -: ADDR_W];
    assign f_size     = root[TAG_BITS + SIZE_W - 1 -: SIZE_W];
    assign f_tag      = root[TAG_BITS-1:0];
    assign f_same     = f_found && (f_base == addr_reg);
    assign offset     = addr_reg - f_base;
    // zero size means the region runs without limit
    assign f_covers   = (f_size == '0) || (f_size > offset);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    // ---- sequencing ----
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        tag_next       = tag_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        etag_next      = etag_reg;
        ebase_next     = ebase_reg;
        esize_next     = esize_reg;
        evalid_next    = evalid_reg;
        ctrl.cmp_en    = 1'b0;
        ctrl.ins_en    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.op;
                    addr_next  = req.address;
                    size_next  = req.region_size;
                    tag_next   = TAG_BITS'(req.tag);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.cmp_en = 1'b1;
                wait_next   = '0;
                state_next  = S_SEARCH;
            end
            S_SEARCH:
            begin
                // wait here until every registered tree level has been loaded
                wait_next = wait_reg + WAIT_W'(1);
                if (wait_reg == WAIT_W'(LEVELS - 1))
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = arsl_pkg::ST_OK;
                    evalid_next    = 1'b0;
                    etag_next      = '0;
                    ebase_next     = '0;
                    esize_next     = '0;
                    state_next     = S_IDLE;
                    case (op_reg)
                        arsl_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        arsl_pkg::OP_INSERT:
                        begin
                            if (f_same)
                            begin
                                // base already held: report the existing entry
                                status_next = arsl_pkg::ST_DUP;
                                evalid_next = 1'b1;
                                etag_next   = arsl_pkg::TAG_W'(f_tag);
                                ebase_next  = f_base;
                                esize_next  = f_size;
                            end
                            else if (table_full)
                            begin
                                status_next = arsl_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.ins_en = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                evalid_next = 1'b1;
                                etag_next   = arsl_pkg::TAG_W'(tag_reg);
                                ebase_next  = addr_reg;
                                esize_next  = size_reg;
                            end
                        end
                        arsl_pkg::OP_EXACT:
                        begin
                            if (f_same)
                            begin
                                evalid_next = 1'b1;
                                etag_next   = arsl_pkg::TAG_W'(f_tag);
                                ebase_next  = f_base;
                                esize_next  = f_size;
                            end
                            else
                            begin
                                status_next = arsl_pkg::ST_MISS;
                            end
                        end
                        arsl_pkg::OP_CONTAIN:
                        begin
                            if (f_found)
                            begin
                                // floor entry is reported even past its end
                                status_next = f_covers ? arsl_pkg::ST_OK : arsl_pkg::ST_MISS;
                                evalid_next = 1'b1;
                                etag_next   = arsl_pkg::TAG_W'(f_tag);
                                ebase_next  = f_base;
                                esize_next  = f_size;
                            end
                            else
                            begin
                                status_next = arsl_pkg::ST_MISS;
                            end
                        end
                        default:
                        begin
                            status_next = arsl_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        size_reg   <= size_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        etag_reg   <= etag_next;
        ebase_reg  <= ebase_next;
        esize_reg  <= esize_next;
        evalid_reg <= evalid_next;
    end

    // ---- checks ----
    logic [TABLE_DEPTH:0] le_plus;
    assign le_plus = {1'b0, le_vec} + (TABLE_DEPTH + 1)'(1);

    // entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // compare flags form a prefix of the chain, since held bases ascend
    a_le_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> $onehot(le_plus))
        else $error("compare flags are not a prefix");

    // at most one cell claims to be the floor
    a_one_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> $onehot0(floor_vec))
        else $error("more than one floor cell");

    // an accepted insert grows the table by exactly one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance entry count");

    // an insert only shifts the chain when there is room
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |-> (count_reg < CNT_W'(TABLE_DEPTH)))
        else $error("insert into a full table");

endmodule

`default_nettype wire

// ----- tb/address_range_symbol_lookup_test.sv -----
// address_range_symbol_lookup_test: self-checking bench for the sorted region table
// depends on arsl_pkg, arsl_req_if, arsl_rsp_if and address_range_symbol_lookup
`default_nettype none

module address_range_symbol_lookup_test;

    localparam int TABLE_DEPTH = arsl_pkg::DEFAULT_TABLE_DEPTH;
    localparam int TAG_BITS    = arsl_pkg::DEFAULT_TAG_BITS;
    localparam int OP_W        = arsl_pkg::OP_W;
    localparam int ADDR_W      = arsl_pkg::ADDR_W;
    localparam int SIZE_W      = arsl_pkg::SIZE_W;
    localparam int TAG_W       = arsl_pkg::TAG_W;
    localparam int STATUS_W    = arsl_pkg::STATUS_W;
    localparam int CYCLE_LIMIT = 500000;
    // allows for the item latency of the block, with margin
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] region_size;
        logic [TAG_W-1:0]  tag;
    } region_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    entry_tag;
        logic [ADDR_W-1:0]   entry_base;
        logic [SIZE_W-1:0]   entry_size;
        logic                entry_valid;
    } region_result_t;

    logic clk = 1'b0;
    logic rst_n;

    arsl_req_if req ();
    arsl_rsp_if rsp ();

    address_range_symbol_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    // requests waiting for the driver, results waiting for the block
    region_request_t queued_requests[$];
    region_result_t  awaited_results[$];

    // addresses handed to inserts since the last clear, used to aim lookups
    logic [ADDR_W-1:0] gen_bases[$];

    // idle and stall rates of the current phase, in percent
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------
    // predictor: shadow of the sorted table
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] held_base[TABLE_DEPTH];
    logic [SIZE_W-1:0] held_size[TABLE_DEPTH];
    logic [TAG_W-1:0]  held_tag[TABLE_DEPTH];
    int unsigned       held_count = 0;

    // number of held regions with base at or below addr
    function automatic int unsigned floor_count(logic [ADDR_W-1:0] addr);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = held_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (held_base[mid] <= addr)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic region_result_t entry_result(logic [STATUS_W-1:0] status,
                                                    int unsigned idx, bit with_entry);
        region_result_t r;
        r = '0;
        r.status = status;
        if (with_entry)
        begin
            r.entry_tag   = held_tag[idx];
            r.entry_base  = held_base[idx];
            r.entry_size  = held_size[idx];
            r.entry_valid = 1'b1;
        end
        return r;
    endfunction

    // applies one operation to the shadow table and returns its result
    function automatic region_result_t apply_region_op(region_request_t rq);
        int unsigned n;
        logic [SIZE_W-1:0] offset;
        logic [TAG_W-1:0] stored_tag;
        stored_tag = rq.tag & TAG_W'((64'd1 << TAG_BITS) - 1);
        if (rq.op == arsl_pkg::OP_CLEAR)
        begin
            held_count = 0;
            return entry_result(arsl_pkg::ST_OK, 0, 1'b0);
        end
        n = floor_count(rq.address);
        if (rq.op == arsl_pkg::OP_INSERT)
        begin
            // duplicate base wins over a full table
            if (n > 0 && held_base[n-1] == rq.address)
                return entry_result(arsl_pkg::ST_DUP, n - 1, 1'b1);
            if (held_count >= TABLE_DEPTH)
                return entry_result(arsl_pkg::ST_FULL, 0, 1'b0);
            for (int i = held_count; i > n; i--)
            begin
                held_base[i] = held_base[i-1];
                held_size[i] = held_size[i-1];
                held_tag[i]  = held_tag[i-1];
            end
            held_base[n] = rq.address;
            held_size[n] = rq.region_size;
            held_tag[n]  = stored_tag;
            held_count++;
            return entry_result(arsl_pkg::ST_OK, n, 1'b1);
        end
        // nothing at or below the address
        if (n == 0)
            return entry_result(arsl_pkg::ST_MISS, 0, 1'b0);
        if (rq.op == arsl_pkg::OP_EXACT)
        begin
            if (held_base[n-1] == rq.address)
                return entry_result(arsl_pkg::ST_OK, n - 1, 1'b1);
            return entry_result(arsl_pkg::ST_MISS, 0, 1'b0);
        end
        // containing lookup: size zero covers everything above the base
        offset = rq.address - held_base[n-1];
        if (held_size[n-1] == '0 || held_size[n-1] > offset)
            return entry_result(arsl_pkg::ST_OK, n - 1, 1'b1);
        return entry_result(arsl_pkg::ST_MISS, n - 1, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    task automatic push_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] address,
                                logic [SIZE_W-1:0] region_size, logic [TAG_W-1:0] tag);
        region_request_t rq;
        rq.op          = op;
        rq.address     = address;
        rq.region_size = region_size;
        rq.tag         = tag;
        queued_requests = {queued_requests, rq};
        if (op == arsl_pkg::OP_INSERT)
            gen_bases = {gen_bases, address};
        else if (op == arsl_pkg::OP_CLEAR)
            gen_bases.delete();
    endtask

    function automatic logic [ADDR_W-1:0] pick_known_base();
        if (gen_bases.size() == 0)
            return $urandom();
        return gen_bases[$urandom_range(gen_bases.size() - 1)];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_insert_base();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return $urandom();
        if (roll < 80)
            return pick_known_base() + $urandom_range(1, 'h200);
        if (roll < 90)
            return pick_known_base();
        return roll[0] ? '1 : '0;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_region_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 65)
            return $urandom_range(1, 'h400);
        if (roll < 90)
            return $urandom();
        return '1;
    endfunction

    // lookups land on, just past, just below or far from a known base
    function automatic logic [ADDR_W-1:0] pick_lookup_address();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return pick_known_base();
        if (roll < 60)
            return pick_known_base() + $urandom_range(0, 'h600);
        if (roll < 75)
            return pick_known_base() - 1;
        return $urandom();
    endfunction

    // a clear followed by a random mix; fill_table pushes mostly inserts
    // so that the table runs full and refuses further regions
    task automatic gen_session(int n_items, bit fill_table);
        int unsigned roll;
        int unsigned inserts;
        inserts = 0;
        push_request(arsl_pkg::OP_CLEAR, $urandom(), $urandom(), TAG_W'($urandom()));
        for (int i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(99);
            if ((fill_table && inserts < 300 && roll < 85) || (!fill_table && roll < 40))
            begin
                push_request(arsl_pkg::OP_INSERT, pick_insert_base(), pick_region_size(),
                             TAG_W'($urandom()));
                inserts++;
            end
            else if (!fill_table && roll >= 97)
                push_request(arsl_pkg::OP_CLEAR, $urandom(), $urandom(), TAG_W'($urandom()));
            else if (roll[0])
                push_request(arsl_pkg::OP_EXACT, pick_lookup_address(), $urandom(),
                             TAG_W'($urandom()));
            else
                push_request(arsl_pkg::OP_CONTAIN, pick_lookup_address(), $urandom(),
                             TAG_W'($urandom()));
        end
    endtask

    task automatic gen_directed();
        push_request(arsl_pkg::OP_CLEAR,   32'h0000_0000, 32'h0000_0000, 16'h0000);
        // empty table
        push_request(arsl_pkg::OP_CONTAIN, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_EXACT,   32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        push_request(arsl_pkg::OP_INSERT,  32'h0000_1000, 32'h0000_0100, 16'hFFFF);
        // lowest base, unlimited size
        push_request(arsl_pkg::OP_INSERT,  32'h0000_0000, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234);
        push_request(arsl_pkg::OP_INSERT,  32'h8000_0000, 32'h0000_0010, 16'hA5A5);
        // duplicate base keeps the earlier region
        push_request(arsl_pkg::OP_INSERT,  32'h0000_1000, 32'h0000_0005, 16'h0007);
        push_request(arsl_pkg::OP_EXACT,   32'h0000_1000, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_EXACT,   32'h0000_1001, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_EXACT,   32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
        // last byte inside, first byte past the end
        push_request(arsl_pkg::OP_CONTAIN, 32'h0000_10FF, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CONTAIN, 32'h0000_1100, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CONTAIN, 32'h7FFF_FFFF, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CONTAIN, 32'h0000_0800, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CONTAIN, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CONTAIN, 32'h8000_000F, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CONTAIN, 32'h8000_0010, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_request(arsl_pkg::OP_INSERT,  32'h0000_0500, 32'h0000_0020, 16'h0001);
        // below the lowest base
        push_request(arsl_pkg::OP_CONTAIN, 32'h0000_04FF, 32'h0000_0000, 16'h0000);
        push_request(arsl_pkg::OP_EXACT,   32'h0000_0000, 32'h0000_0000, 16'h0000);
        // insert in front shifts the table up
        push_request(arsl_pkg::OP_INSERT,  32'h0000_0400, 32'hFFFF_FFFF, 16'h0002);
        push_request(arsl_pkg::OP_CONTAIN, 32'h0000_0600, 32'h0000_0000, 16'h0000);
    endtask

    // ------------------------------------------------------------------
    // request driver: next item goes out once the current one has transferred
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.op          <= arsl_pkg::OP_CLEAR;
            req.address     <= '0;
            req.region_size <= '0;
            req.tag         <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                region_request_t rq;
                rq = queued_requests.pop_front();
                req.valid       <= 1'b1;
                req.op          <= rq.op;
                req.address     <= rq.address;
                req.region_size <= rq.region_size;
                req.tag         <= rq.tag;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on request transfers, checks result transfers
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] expected_value,
                               logic [63:0] actual_value);
        if (expected_value !== actual_value)
        begin
            $error("%s: expected %0h, got %0h", name, expected_value, actual_value);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    region_result_t want;
                    want = awaited_results.pop_front();
                    check_field("status",      want.status,      rsp.status);
                    check_field("entry_tag",   want.entry_tag,   rsp.entry_tag);
                    check_field("entry_base",  want.entry_base,  rsp.entry_base);
                    check_field("entry_size",  want.entry_size,  rsp.entry_size);
                    check_field("entry_valid", want.entry_valid, rsp.entry_valid);
                end
            end

            if (req.valid && req.ready)
            begin
                region_request_t seen;
                seen.op          = req.op;
                seen.address     = req.address;
                seen.region_size = req.region_size;
                seen.tag         = req.tag;
                awaited_results = {awaited_results, apply_region_op(seen)};
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequencing: reset, then four idling phases
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (queued_requests.size() != 0 || req.valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gen_directed();
        gen_session(260, 1'b0);
        wait_drained();

        // sparse sender
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        gen_session(260, 1'b0);
        wait_drained();

        // slow receiver, results back up
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        gen_session(260, 1'b0);
        wait_drained();

        // light idling on both sides while the table runs full
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        gen_session(380, 1'b1);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/arsl_pkg.sv
rtl/arsl_req_if.sv
rtl/arsl_rsp_if.sv
rtl/arsl_cell.sv
rtl/arsl_or_tree.sv
rtl/address_range_symbol_lookup.sv
tb/address_range_symbol_lookup_test.sv
